>>> design/chasap_pkg.sv
// Shared constants for the per-channel as-soon-as-possible scheduler.
package chasap_pkg;

    localparam int FIELD_BITS = 48;
    localparam int MASK_BITS = 16;
    localparam int DEF_NUM_CHANNELS = 16;
    localparam int DEF_TIME_BITS = 48;
    localparam int MERGE_GROUP = 8;

endpackage

>>> design/chasap_lane.sv
// One channel lane: holds the channel end time and offers it when selected.
module chasap_lane import chasap_pkg::*; #(
    parameter int TIME_BITS = DEF_TIME_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 sel,
    input  logic                 upd,
    input  logic [TIME_BITS-1:0] new_end,
    output logic [TIME_BITS-1:0] masked_end
);

    logic [TIME_BITS-1:0] end_reg;
    logic [TIME_BITS-1:0] end_next;

    always_comb begin
        end_next = end_reg;
        if (upd && sel && (new_end > end_reg)) begin
            end_next = new_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            end_reg <= '0;
        end else begin
            end_reg <= end_next;
        end
    end

    assign masked_end = sel ? end_reg : '0;

endmodule

>>> design/chasap_merge.sv
// Two-level registered maximum tree over the values offered by the lanes.
module chasap_merge import chasap_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int TIME_BITS    = DEF_TIME_BITS
) (
    input  logic                 aclk,
    input  logic                 load_grp,
    input  logic                 load_top,
    input  logic [TIME_BITS-1:0] lane_val [NUM_CHANNELS],
    output logic [TIME_BITS-1:0] max_val
);

    localparam int NUM_GROUPS = (NUM_CHANNELS + MERGE_GROUP - 1) / MERGE_GROUP;
    localparam int PAD_DEPTH = NUM_GROUPS * MERGE_GROUP;

    logic [TIME_BITS-1:0] padded [PAD_DEPTH];
    logic [TIME_BITS-1:0] grp_reg [NUM_GROUPS];
    logic [TIME_BITS-1:0] grp_next [NUM_GROUPS];
    logic [TIME_BITS-1:0] max_reg;
    logic [TIME_BITS-1:0] max_next;

    for (genvar i = 0; i < PAD_DEPTH; i++) begin : g_pad
        if (i < NUM_CHANNELS) begin : g_used
            assign padded[i] = lane_val[i];
        end else begin : g_unused
            assign padded[i] = '0;
        end
    end

    always_comb begin
        for (int g = 0; g < NUM_GROUPS; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < MERGE_GROUP; k++) begin
                if (padded[g*MERGE_GROUP+k] > grp_next[g]) begin
                    grp_next[g] = padded[g*MERGE_GROUP+k];
                end
            end
        end
    end

    always_comb begin
        max_next = '0;
        for (int g = 0; g < NUM_GROUPS; g++) begin
            if (grp_reg[g] > max_next) begin
                max_next = grp_reg[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_grp) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                grp_reg[g] <= grp_next[g];
            end
        end
        if (load_top) begin
            max_reg <= max_next;
        end
    end

    assign max_val = max_reg;

endmodule

>>> design/channel_asap_scheduler_core.sv
// Per-channel as-soon-as-possible scheduler: sequencer, lanes and merge tree.
// A beat is taken only in the idle state, and s_ready stays low until the
// current beat is through: the two-level merge tree loads its group and top
// registers, the start adder registers start and end, then the lane update runs.
// A held result stalls the lane update until the result beat is taken.
// Reset (aresetn low, synchronous) clears all channel end times, the touched
// set, the schedule length and the result valid flag.
module channel_asap_scheduler_core import chasap_pkg::*; #(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int TIME_BITS    = DEF_TIME_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [MASK_BITS-1:0]  s_channel_mask,
    input  logic [FIELD_BITS-1:0] s_pulse_length,
    input  logic                  s_use_given_start,
    input  logic [FIELD_BITS-1:0] s_given_start,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [FIELD_BITS-1:0] m_start_time,
    output logic [FIELD_BITS-1:0] m_end_time,
    output logic [FIELD_BITS-1:0] m_schedule_length
);

    localparam int WIDE_BITS = (TIME_BITS > FIELD_BITS) ? TIME_BITS : FIELD_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GRP,
        S_TOP,
        S_ADD,
        S_UPD
    } state_t;

    state_t                state_reg;
    state_t                state_next;
    logic [MASK_BITS-1:0]  mask_reg;
    logic [MASK_BITS-1:0]  touched_reg;
    logic [MASK_BITS-1:0]  touched_next;
    logic [MASK_BITS-1:0]  valid_chan;
    logic [TIME_BITS-1:0]  len_reg;
    logic [TIME_BITS-1:0]  given_reg;
    logic                  use_given_reg;
    logic [TIME_BITS-1:0]  start_reg;
    logic [TIME_BITS-1:0]  end_reg;
    logic [TIME_BITS-1:0]  span_reg;
    logic [TIME_BITS-1:0]  span_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    logic [FIELD_BITS-1:0] m_start_reg;
    logic [FIELD_BITS-1:0] m_end_reg;
    logic [FIELD_BITS-1:0] m_span_reg;

    logic [WIDE_BITS-1:0]  len_wide;
    logic [WIDE_BITS-1:0]  given_wide;
    logic [WIDE_BITS-1:0]  start_wide;
    logic [WIDE_BITS-1:0]  end_wide;
    logic [WIDE_BITS-1:0]  span_wide;
    logic [TIME_BITS-1:0]  start_sel;
    logic [TIME_BITS:0]    sum;
    logic [TIME_BITS-1:0]  sum_sat;
    logic                  accept;
    logic                  upd_go;
    logic                  any_sel;

    logic [NUM_CHANNELS-1:0] lane_sel;
    logic [TIME_BITS-1:0]    lane_val [NUM_CHANNELS];
    logic [TIME_BITS-1:0]    merge_max;

    for (genvar i = 0; i < MASK_BITS; i++) begin : g_valid
        assign valid_chan[i] = (i < NUM_CHANNELS);
    end

    for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_lane
        if (ch < MASK_BITS) begin : g_sel
            assign lane_sel[ch] = mask_reg[ch];
        end else begin : g_nosel
            assign lane_sel[ch] = 1'b0;
        end

        chasap_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .sel        (lane_sel[ch]),
            .upd        (upd_go),
            .new_end    (end_reg),
            .masked_end (lane_val[ch])
        );
    end

    chasap_merge #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TIME_BITS    (TIME_BITS)
    ) u_merge (
        .aclk     (aclk),
        .load_grp (state_reg == S_GRP),
        .load_top (state_reg == S_TOP),
        .lane_val (lane_val),
        .max_val  (merge_max)
    );

    assign accept = s_valid && s_ready;
    assign upd_go = (state_reg == S_UPD) && (!m_valid_reg || m_ready);
    assign any_sel = |(mask_reg & valid_chan);

    assign len_wide = WIDE_BITS'(s_pulse_length);
    assign given_wide = WIDE_BITS'(s_given_start);

    assign start_sel = use_given_reg ? given_reg : merge_max;
    assign sum = {1'b0, start_sel} + {1'b0, len_reg};
    assign sum_sat = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

    always_comb begin
        state_next = state_reg;
        m_valid_next = m_valid_reg;
        touched_next = touched_reg;
        span_next = span_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_GRP;
                end
            end
            S_GRP: begin
                state_next = S_TOP;
            end
            S_TOP: begin
                state_next = S_ADD;
            end
            S_ADD: begin
                state_next = S_UPD;
            end
            S_UPD: begin
                if (upd_go) begin
                    state_next = S_IDLE;
                    m_valid_next = 1'b1;
                    touched_next = touched_reg | (mask_reg & valid_chan);
                    if (any_sel && (end_reg > span_reg)) begin
                        span_next = end_reg;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign start_wide = WIDE_BITS'(start_reg);
    assign end_wide = WIDE_BITS'(end_reg);
    assign span_wide = WIDE_BITS'(span_next);

    always_ff @(posedge aclk) begin
        if (accept) begin
            mask_reg <= (s_channel_mask == '0) ? touched_reg : s_channel_mask;
            len_reg <= len_wide[TIME_BITS-1:0];
            given_reg <= given_wide[TIME_BITS-1:0];
            use_given_reg <= s_use_given_start;
        end
        if (state_reg == S_ADD) begin
            start_reg <= start_sel;
            end_reg <= sum_sat;
        end
        if (upd_go) begin
            m_start_reg <= start_wide[FIELD_BITS-1:0];
            m_end_reg <= end_wide[FIELD_BITS-1:0];
            m_span_reg <= span_wide[FIELD_BITS-1:0];
        end
        if (!aresetn) begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
            touched_reg <= '0;
            span_reg <= '0;
        end else begin
            state_reg <= state_next;
            m_valid_reg <= m_valid_next;
            touched_reg <= touched_next;
            span_reg <= span_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_start_time = m_start_reg;
    assign m_end_time = m_end_reg;
    assign m_schedule_length = m_span_reg;

    a_end_not_before_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_UPD) |-> (end_reg >= start_reg))
        else $error("Pulse end time is earlier than its start time.");

    a_span_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> (span_reg >= $past(span_reg)))
        else $error("Schedule length decreased.");

    a_span_covers_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (upd_go && any_sel) |=> (span_reg >= $past(end_reg)))
        else $error("Schedule length is below the end of an updated pulse.");

    a_update_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_UPD) && m_valid_reg && !m_ready) |=> (state_reg == S_UPD))
        else $error("Lane update went ahead while the result beat was held.");

    a_touched_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (touched_reg & ~valid_chan) == '0)
        else $error("A channel beyond the channel count is marked as touched.");

endmodule

>>> sim/tb_channel_asap_scheduler_core.sv
// Self-checking testbench for the per-channel as-soon-as-possible scheduler core.
`timescale 1ns / 1ps

module tb_channel_asap_scheduler_core;
    import chasap_pkg::*;

    localparam int NCH = DEF_NUM_CHANNELS;
    localparam logic [FIELD_BITS-1:0] TIME_MAX = '1;
    localparam int RANDOM_PULSES = 1500;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int LONG_HOLD_AT = 300;

    typedef struct packed {
        logic [MASK_BITS-1:0]  mask;
        logic [FIELD_BITS-1:0] len;
        logic                  use_given;
        logic [FIELD_BITS-1:0] given;
    } pulse_beat_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] start_time;
        logic [FIELD_BITS-1:0] end_time;
        logic [FIELD_BITS-1:0] schedule_length;
    } slot_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [MASK_BITS-1:0]  s_channel_mask = '0;
    logic [FIELD_BITS-1:0] s_pulse_length = '0;
    logic                  s_use_given_start = 1'b0;
    logic [FIELD_BITS-1:0] s_given_start = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [FIELD_BITS-1:0] m_start_time;
    logic [FIELD_BITS-1:0] m_end_time;
    logic [FIELD_BITS-1:0] m_schedule_length;

    pulse_beat_t pending_pulses[$];
    slot_t       expected_slots[$];

    logic [FIELD_BITS-1:0] chan_end[NCH];
    logic [MASK_BITS-1:0]  touched = '0;

    int n_errors = 0;
    int n_accepted = 0;
    int n_results = 0;
    int n_issued = 0;
    int n_explicit = 0;
    int n_barriers = 0;
    int n_empty_sel = 0;
    int n_saturated = 0;
    logic [FIELD_BITS-1:0] horizon = '0;

    channel_asap_scheduler_core #(
        .NUM_CHANNELS(DEF_NUM_CHANNELS),
        .TIME_BITS   (DEF_TIME_BITS)
    ) i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_channel_mask   (s_channel_mask),
        .s_pulse_length   (s_pulse_length),
        .s_use_given_start(s_use_given_start),
        .s_given_start    (s_given_start),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_start_time     (m_start_time),
        .m_end_time       (m_end_time),
        .m_schedule_length(m_schedule_length)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic slot_t predict_slot(pulse_beat_t b);
        logic [MASK_BITS-1:0]  sel;
        logic [FIELD_BITS-1:0] t0;
        logic [FIELD_BITS:0]   sum;
        slot_t                 r;
        sel = (b.mask == '0) ? touched : b.mask;
        if (sel == '0) n_empty_sel++;
        if (b.len == '0) n_barriers++;
        t0 = '0;
        if (b.use_given) begin
            t0 = b.given;
            n_explicit++;
        end else begin
            for (int ch = 0; ch < NCH; ch++) begin
                if (sel[ch] && chan_end[ch] > t0) t0 = chan_end[ch];
            end
        end
        sum = {1'b0, t0} + {1'b0, b.len};
        r.start_time = t0;
        r.end_time = sum[FIELD_BITS] ? TIME_MAX : sum[FIELD_BITS-1:0];
        if (sum[FIELD_BITS]) n_saturated++;
        r.schedule_length = '0;
        for (int ch = 0; ch < NCH; ch++) begin
            if (sel[ch]) begin
                if (r.end_time > chan_end[ch]) chan_end[ch] = r.end_time;
                touched[ch] = 1'b1;
            end
            if (chan_end[ch] > r.schedule_length) r.schedule_length = chan_end[ch];
        end
        return r;
    endfunction

    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_pulse(logic [MASK_BITS-1:0] mask, logic [FIELD_BITS-1:0] len,
                              logic use_given, logic [FIELD_BITS-1:0] given);
        pulse_beat_t b;
        b.mask = mask;
        b.len = len;
        b.use_given = use_given;
        b.given = given;
        pending_pulses.insert(pending_pulses.size(), b);
    endtask

    task automatic push_random_pulse();
        logic [63:0]           wide;
        logic [MASK_BITS-1:0]  mask;
        logic [FIELD_BITS-1:0] len;
        logic [FIELD_BITS-1:0] given;
        logic [FIELD_BITS-1:0] offset;
        logic                  use_given;
        int                    r;
        wide = {$urandom(), $urandom()};
        r = $urandom_range(0, 99);
        if (r < 10) mask = '0;
        else if (r < 20) mask = MASK_BITS'(1) << $urandom_range(0, MASK_BITS - 1);
        else if (r < 28) mask = '1;
        else mask = MASK_BITS'($urandom());
        r = $urandom_range(0, 99);
        if (r < 15) len = '0;
        else if (r < 75) len = FIELD_BITS'($urandom_range(1, 1000));
        else if (r < 96) len = FIELD_BITS'($urandom_range(1, 1 << 20));
        else len = FIELD_BITS'($urandom());
        use_given = ($urandom_range(0, 3) == 0);
        if (use_given) begin
            offset = FIELD_BITS'($urandom_range(0, 100000));
            if ($urandom_range(0, 1) == 1) given = horizon + offset;
            else given = (horizon > offset) ? horizon - offset : '0;
        end else begin
            // The given start is ignored here, so its full range is exercised freely.
            given = wide[FIELD_BITS-1:0];
        end
        horizon = horizon + len;
        push_pulse(mask, len, use_given, given);
    endtask

    // Driver: one beat in flight, loaded from the pending queue with random gaps.
    always @(posedge aclk) begin
        int          gap_left;
        pulse_beat_t b;
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                b.mask = s_channel_mask;
                b.len = s_pulse_length;
                b.use_given = s_use_given_start;
                b.given = s_given_start;
                expected_slots.insert(expected_slots.size(), predict_slot(b));
                n_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_pulses.size() > 0) begin
                    b = pending_pulses.pop_front();
                    s_channel_mask <= b.mask;
                    s_pulse_length <= b.len;
                    s_use_given_start <= b.use_given;
                    s_given_start <= b.given;
                    s_valid <= 1'b1;
                    n_issued++;
                    gap_left = pick_gap(n_issued >= 700 && n_issued < 900);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result beat and drives the receiver's back-pressure.
    always @(posedge aclk) begin
        int    stall_left;
        bit    long_hold_done;
        slot_t exp_slot;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
            long_hold_done = 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_slots.size() == 0) begin
                    $error("Unexpected result beat: start_time %0h", m_start_time);
                    n_errors++;
                end else begin
                    exp_slot = expected_slots.pop_front();
                    if (m_start_time !== exp_slot.start_time) begin
                        $error("start_time mismatch: expected %0h, actual %0h",
                               exp_slot.start_time, m_start_time);
                        n_errors++;
                    end
                    if (m_end_time !== exp_slot.end_time) begin
                        $error("end_time mismatch: expected %0h, actual %0h",
                               exp_slot.end_time, m_end_time);
                        n_errors++;
                    end
                    if (m_schedule_length !== exp_slot.schedule_length) begin
                        $error("schedule_length mismatch: expected %0h, actual %0h",
                               exp_slot.schedule_length, m_schedule_length);
                        n_errors++;
                    end
                end
            end
            if (!long_hold_done && n_results >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                stall_left = pick_gap(n_results >= 1000 && n_results < 1200);
            end
        end
    end

    always @(posedge aclk) begin
        int idle_cycles;
        if (!aresetn) begin
            idle_cycles = 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        for (int ch = 0; ch < NCH; ch++) chan_end[ch] = '0;

        // Empty selection before any channel is touched, including saturation.
        push_pulse('0, 48'd100, 1'b0, '0);
        push_pulse('0, TIME_MAX, 1'b1, TIME_MAX);
        push_pulse('0, '0, 1'b1, 48'd1234);
        push_pulse(16'h0001, 48'd50, 1'b0, '0);
        push_pulse(16'h8000, '0, 1'b0, '0);
        push_pulse(16'hFFFF, 48'd10, 1'b0, '0);
        push_pulse('0, '0, 1'b0, '0);
        // Explicit start before the existing end leaves the later end in place.
        push_pulse(16'h0003, 48'd3, 1'b1, 48'd5);
        push_pulse(16'h0002, 48'd20, 1'b1, 48'd1000);
        push_pulse(16'h0006, 48'd7, 1'b0, '0);
        push_pulse(16'hAAAA, 48'd333, 1'b0, '0);
        push_pulse(16'h5555, 48'd1, 1'b0, TIME_MAX);
        push_pulse(16'h0100, 48'd0, 1'b1, 48'd5000);
        push_pulse('0, 48'd17, 1'b0, 48'h5555_5555_5555);
        push_pulse(16'h4000, 48'd2, 1'b0, 48'hAAAA_AAAA_AAAA);
        horizon = 48'd6000;

        for (int i = 0; i < RANDOM_PULSES; i++) push_random_pulse();

        // Saturating updates come last, since a channel stays at the maximum afterwards.
        push_pulse(16'h00F0, 48'd100, 1'b1, TIME_MAX - 48'd5);
        push_pulse(16'h0010, 48'd1, 1'b0, '0);
        push_pulse(16'h0001, '0, 1'b1, TIME_MAX);
        push_pulse('0, '0, 1'b0, '0);
        push_pulse(16'hFFFF, TIME_MAX, 1'b0, '0);
        push_pulse(16'h0300, 48'd9, 1'b1, 48'd1);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_pulses.size() > 0 || s_valid) @(negedge aclk);
        while (expected_slots.size() > 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Run covered %0d pulse beats and %0d result beats: %0d explicit, %0d barriers,",
                 n_accepted, n_results, n_explicit, n_barriers);
        $display("%0d empty selections and %0d saturated end times, under random back-pressure.",
                 n_empty_sel, n_saturated);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
